@@ hw/rtl/smr_pkg.sv @@
// ----------------------------------------------------------------------------
// smr_pkg
// Shared widths and register indexes for the spiral order matrix reader.
// ----------------------------------------------------------------------------
package smr_pkg;

	localparam int VALUE_WIDTH     = 32;
	localparam int CFG_WIDTH       = 4;
	localparam int CFG_INDEX_WIDTH = 1;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_COUNT    = 1'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLUMN_COUNT = 1'd1;

endpackage

@@ hw/rtl/smr_element_if.sv @@
// ----------------------------------------------------------------------------
// smr_element_if
// Input channel: one matrix element per beat, row-major order.
// ----------------------------------------------------------------------------
interface smr_element_if;

	logic                                  valid;
	logic                                  ready;
	logic signed [smr_pkg::VALUE_WIDTH-1:0] element_value;

	modport source (output valid, output element_value, input ready);
	modport sink   (input valid, input element_value, output ready);

endinterface

@@ hw/rtl/smr_result_if.sv @@
// ----------------------------------------------------------------------------
// smr_result_if
// Output channel: one element in spiral order per beat, with a last flag.
// ----------------------------------------------------------------------------
interface smr_result_if;

	logic                                  valid;
	logic                                  ready;
	logic signed [smr_pkg::VALUE_WIDTH-1:0] out_value;
	logic                                  is_last;

	modport source (output valid, output out_value, output is_last, input ready);
	modport sink   (input valid, input out_value, input is_last, output ready);

endinterface

@@ hw/rtl/spiral_order_matrix_reader.sv @@
// ----------------------------------------------------------------------------
// spiral_order_matrix_reader
// Stores a matrix loaded in row-major order and replays it in clockwise
// spiral order once the final element has arrived.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                    | beat
//  element   | in  | element_value              | one element, row-major
//  result    | out | out_value, is_last         | one element, spiral order
//  cfg       | in  | cfg_we, cfg_index, cfg_wdata | one register write
//
//  element.ready stays high while loading. The final element switches to
//  replay: element.ready is low while the walker issues one store read per
//  cycle when there are no result stalls (the read stage, then the output
//  register).
//  Result stalls hold the read stage and halt the walker.
//  Reset clears control state only; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader #(
	parameter int MAX_ROWS   = 8,
	parameter int MAX_COLS   = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [smr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [smr_pkg::CFG_WIDTH-1:0]         cfg_wdata,
	smr_element_if.sink                           element,
	smr_result_if.source                          result
);

	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int AW    = RW + CW;
	localparam int DEPTH = 2 ** AW;
	localparam int CNTW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
	localparam int SW    = (DATA_WIDTH < smr_pkg::VALUE_WIDTH) ? DATA_WIDTH
	                                                          : smr_pkg::VALUE_WIDTH;
	localparam int CFW   = smr_pkg::CFG_WIDTH;

	typedef enum logic {ST_LOAD, ST_EMIT} state_t;
	typedef enum logic [2:0] {WK_RIGHT, WK_DOWN, WK_LEFT, WK_UP, WK_ROW, WK_COL} walk_t;

	function automatic walk_t lap_dir(input logic [RW-1:0] t, input logic [RW-1:0] b,
	                                  input logic [CW-1:0] l, input logic [CW-1:0] r);
		walk_t d;
		if (t == b) begin
			d = WK_ROW;
		end else if (l == r) begin
			d = WK_COL;
		end else begin
			d = WK_RIGHT;
		end
		return d;
	endfunction

	state_t           state_q;
	logic [CFW-1:0]   rows_q, cols_q;
	logic [RW-1:0]    load_row_q;
	logic [CW-1:0]    load_col_q;

	walk_t            dir_q, dir_d;
	logic [RW-1:0]    top_q, bot_q, wr_q, top_d, bot_d, wr_d;
	logic [CW-1:0]    left_q, right_q, wc_q, left_d, right_d, wc_d;
	logic [CNTW-1:0]  emit_left_q;

	logic             rd_valid_s1, rd_last_s1;
	logic [SW-1:0]    mem_rdata_s1;
	logic             out_valid_q, out_last_q;
	logic [smr_pkg::VALUE_WIDTH-1:0] out_value_q;

	logic [SW-1:0]    mem [DEPTH];

	logic             load_acc, load_row_end, load_col_end;
	logic             s1_adv, rd_issue;
	logic [CFW-1:0]   cfg_clamp_rows, cfg_clamp_cols;
	logic [2*CFW-1:0] total;
	logic [RW-1:0]    bot_init;
	logic [CW-1:0]    right_init;

	assign load_acc     = element.valid && element.ready;
	assign load_col_end = (load_col_q == CW'(cols_q - CFW'(1)));
	assign load_row_end = (load_row_q == RW'(rows_q - CFW'(1)));
	assign s1_adv       = rd_valid_s1 && (!out_valid_q || result.ready);
	assign rd_issue     = (state_q == ST_EMIT) && (!rd_valid_s1 || s1_adv);

	assign total      = (2*CFW)'(rows_q) * (2*CFW)'(cols_q);
	assign bot_init   = RW'(rows_q - CFW'(1));
	assign right_init = CW'(cols_q - CFW'(1));

	assign cfg_clamp_rows = (cfg_wdata == '0) ? CFW'(1) :
	                        (cfg_wdata > CFW'(MAX_ROWS)) ? CFW'(MAX_ROWS) : cfg_wdata;
	assign cfg_clamp_cols = (cfg_wdata == '0) ? CFW'(1) :
	                        (cfg_wdata > CFW'(MAX_COLS)) ? CFW'(MAX_COLS) : cfg_wdata;

	assign element.ready    = (state_q == ST_LOAD);
	assign result.valid     = out_valid_q;
	assign result.out_value = out_value_q;
	assign result.is_last   = out_last_q;

	// next walker position
	always_comb begin
		dir_d   = dir_q;
		wr_d    = wr_q;
		wc_d    = wc_q;
		top_d   = top_q;
		bot_d   = bot_q;
		left_d  = left_q;
		right_d = right_q;
		unique case (dir_q)
			WK_RIGHT: begin
				if (wc_q == CW'(right_q - CW'(1))) begin
					dir_d = WK_DOWN;
					wc_d  = right_q;
				end else begin
					wc_d = wc_q + CW'(1);
				end
			end
			WK_DOWN: begin
				if (wr_q == RW'(bot_q - RW'(1))) begin
					dir_d = WK_LEFT;
					wr_d  = bot_q;
				end else begin
					wr_d = wr_q + RW'(1);
				end
			end
			WK_LEFT: begin
				if (wc_q == CW'(left_q + CW'(1))) begin
					dir_d = WK_UP;
					wc_d  = left_q;
				end else begin
					wc_d = wc_q - CW'(1);
				end
			end
			WK_UP: begin
				if (wr_q == RW'(top_q + RW'(1))) begin
					top_d   = top_q + RW'(1);
					bot_d   = bot_q - RW'(1);
					left_d  = left_q + CW'(1);
					right_d = right_q - CW'(1);
					wr_d    = top_d;
					wc_d    = left_d;
					dir_d   = lap_dir(top_d, bot_d, left_d, right_d);
				end else begin
					wr_d = wr_q - RW'(1);
				end
			end
			WK_ROW: wc_d = wc_q + CW'(1);
			WK_COL: wr_d = wr_q + RW'(1);
			default: dir_d = WK_ROW;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			rows_q      <= CFW'(1);
			cols_q      <= CFW'(1);
			load_row_q  <= '0;
			load_col_q  <= '0;
			dir_q       <= WK_ROW;
			wr_q        <= '0;
			wc_q        <= '0;
			top_q       <= '0;
			bot_q       <= '0;
			left_q      <= '0;
			right_q     <= '0;
			emit_left_q <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_value_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					smr_pkg::REG_ROW_COUNT:    rows_q <= cfg_clamp_rows;
					smr_pkg::REG_COLUMN_COUNT: cols_q <= cfg_clamp_cols;
					default:                   rows_q <= rows_q;
				endcase
				load_row_q <= '0;
				load_col_q <= '0;
			end else if (load_acc) begin
				if (load_col_end) begin
					load_col_q <= '0;
					if (load_row_end) begin
						load_row_q  <= '0;
						state_q     <= ST_EMIT;
						top_q       <= '0;
						left_q      <= '0;
						bot_q       <= bot_init;
						right_q     <= right_init;
						wr_q        <= '0;
						wc_q        <= '0;
						dir_q       <= lap_dir('0, bot_init, '0, right_init);
						emit_left_q <= CNTW'(total - (2*CFW)'(1));
					end else begin
						load_row_q <= load_row_q + RW'(1);
					end
				end else begin
					load_col_q <= load_col_q + CW'(1);
				end
			end

			if (rd_issue) begin
				dir_q       <= dir_d;
				wr_q        <= wr_d;
				wc_q        <= wc_d;
				top_q       <= top_d;
				bot_q       <= bot_d;
				left_q      <= left_d;
				right_q     <= right_d;
				emit_left_q <= emit_left_q - CNTW'(1);
				if (emit_left_q == '0) begin
					state_q <= ST_LOAD;
				end
			end

			if (rd_issue) begin
				rd_valid_s1 <= 1'b1;
				rd_last_s1  <= (emit_left_q == '0);
			end else if (s1_adv) begin
				rd_valid_s1 <= 1'b0;
			end

			if (s1_adv) begin
				out_valid_q <= 1'b1;
				out_last_q  <= rd_last_s1;
				out_value_q <= smr_pkg::VALUE_WIDTH'(mem_rdata_s1);
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_acc) begin
			mem[{load_row_q, load_col_q}] <= element.element_value[SW-1:0];
		end
		if (rd_issue) begin
			mem_rdata_s1 <= mem[{wr_q, wc_q}];
		end
	end

`ifndef SYNTHESIS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_valid_s1 && !s1_adv) |=> (rd_valid_s1 && $stable(mem_rdata_s1)
		                              && $stable(rd_last_s1)))
		else $error("read stage lost or changed while held");

	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_issue && emit_left_q == '0) |=> (state_q == ST_LOAD && rd_last_s1))
		else $error("replay did not end on the last read");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |-> !rd_issue)
		else $error("store read and load in the same cycle");
`endif

endmodule

@@ tb/sv/spiral_order_matrix_reader_tb.sv @@
// ----------------------------------------------------------------------------
// spiral_order_matrix_reader_tb
// Loads matrices of many shapes row by row and checks that every beat comes
// back in clockwise spiral order with the last flag on the final element.
// A shadow copy of the store and the size registers predicts each beat.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader_tb;

	localparam int MAX_ROWS    = 8;
	localparam int MAX_COLS    = 8;
	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	typedef struct packed {
		logic [smr_pkg::VALUE_WIDTH-1:0] value;
		logic                            last;
	} spiral_beat_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                cfg_we;
	logic [smr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [smr_pkg::CFG_WIDTH-1:0]       cfg_wdata;

	smr_element_if element_ch();
	smr_result_if  result_ch();

	spiral_order_matrix_reader #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.DATA_WIDTH (smr_pkg::VALUE_WIDTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.element   (element_ch),
		.result    (result_ch)
	);

	logic [smr_pkg::VALUE_WIDTH-1:0] shadow_mem [STORE_DEPTH];
	logic [smr_pkg::CFG_WIDTH-1:0]   shadow_rows;
	logic [smr_pkg::CFG_WIDTH-1:0]   shadow_cols;
	int                              shadow_fill;
	int                              spiral_pos;
	spiral_beat_t                    pending_spiral [$];
	spiral_beat_t                    want_beat;

	int mismatches    = 0;
	int beats_checked = 0;
	int matrices_seen = 0;
	int items_sent    = 0;
	int send_idle_pct;
	int recv_idle_pct;
	int recv_hold     = 0;
	bit element_held  = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, or a long hold-off while recv_hold runs down
	always @(posedge clk) begin
		if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_spiral.size() == 0) begin
				$display("%0t: beat with nothing pending: expected none, actual value=%h last=%b",
					$time, result_ch.out_value, result_ch.is_last);
				mismatches++;
			end else begin
				want_beat = pending_spiral.pop_front();
				if (result_ch.out_value !== want_beat.value ||
						result_ch.is_last !== want_beat.last) begin
					$display("%0t: spiral beat: expected value=%h last=%b, actual value=%h last=%b",
						$time, want_beat.value, want_beat.last,
						result_ch.out_value, result_ch.is_last);
					mismatches++;
				end
				beats_checked++;
			end
		end
	end

	function automatic int clamp_dim(input logic [smr_pkg::CFG_WIDTH-1:0] raw, input int limit);
		if (raw == 0)
			return 1;
		if (raw > limit)
			return limit;
		return int'(raw);
	endfunction

	function automatic void queue_beat(input int r, input int c, input int total);
		spiral_beat_t b;
		spiral_pos++;
		b.value = shadow_mem[STORE_AW'(r * MAX_COLS + c)];
		b.last  = (spiral_pos == total);
		pending_spiral.push_back(b);
	endfunction

	function automatic void predict_spiral(input int rows, input int cols);
		int top, left, bot, right, i, total;
		top        = 0;
		left       = 0;
		bot        = rows - 1;
		right      = cols - 1;
		total      = rows * cols;
		spiral_pos = 0;
		while (top <= bot && left <= right) begin
			if (top == bot) begin
				for (i = left; i <= right; i++)
					queue_beat(top, i, total);
			end else if (left == right) begin
				for (i = top; i <= bot; i++)
					queue_beat(i, left, total);
			end else begin
				for (i = left; i < right; i++)
					queue_beat(top, i, total);
				for (i = top; i < bot; i++)
					queue_beat(i, right, total);
				for (i = right; i > left; i--)
					queue_beat(bot, i, total);
				for (i = bot; i > top; i--)
					queue_beat(i, left, total);
			end
			top++;
			left++;
			bot--;
			right--;
		end
	endfunction

	function automatic void load_element(input logic [smr_pkg::VALUE_WIDTH-1:0] v);
		int rows, cols, total;
		rows  = clamp_dim(shadow_rows, MAX_ROWS);
		cols  = clamp_dim(shadow_cols, MAX_COLS);
		total = rows * cols;
		if (shadow_fill >= total)
			shadow_fill = 0;
		shadow_mem[STORE_AW'((shadow_fill / cols) * MAX_COLS + shadow_fill % cols)] = v;
		shadow_fill++;
		if (shadow_fill == total) begin
			shadow_fill = 0;
			predict_spiral(rows, cols);
			matrices_seen++;
		end
	endfunction

	function automatic logic [smr_pkg::VALUE_WIDTH-1:0] random_value();
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h7FFF_FFFF;
				default: return 32'h8000_0000;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [smr_pkg::CFG_WIDTH-1:0] pick_dim();
		int x;
		x = $urandom_range(99);
		if (x < 75)
			return smr_pkg::CFG_WIDTH'($urandom_range(1, 4));
		if (x < 90)
			return smr_pkg::CFG_WIDTH'($urandom_range(5, 8));
		return smr_pkg::CFG_WIDTH'($urandom_range(0, 15));
	endfunction

	// valid stays high after a beat unless the next one is delayed
	task automatic release_element();
		if (element_held) begin
			element_ch.valid <= 1'b0;
			element_held = 1'b0;
		end
	endtask

	task automatic send_element(input logic [smr_pkg::VALUE_WIDTH-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			release_element();
			@(posedge clk);
		end
		element_ch.valid         <= 1'b1;
		element_ch.element_value <= v;
		do
			@(posedge clk);
		while (element_ch.ready !== 1'b1);
		element_held = 1'b1;
		load_element(v);
		items_sent++;
	endtask

	task automatic send_matrix(input int total);
		repeat (total)
			send_element(random_value());
	endtask

	task automatic wait_idle();
		release_element();
		while (pending_spiral.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [smr_pkg::CFG_INDEX_WIDTH-1:0] idx,
			input logic [smr_pkg::CFG_WIDTH-1:0] val);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == smr_pkg::REG_ROW_COUNT)
			shadow_rows = val;
		else
			shadow_cols = val;
		shadow_fill = 0;
		@(posedge clk);
	endtask

	task automatic set_dims(input logic [smr_pkg::CFG_WIDTH-1:0] rows,
			input logic [smr_pkg::CFG_WIDTH-1:0] cols);
		write_reg(smr_pkg::REG_ROW_COUNT, rows);
		write_reg(smr_pkg::REG_COLUMN_COUNT, cols);
	endtask

	task automatic test_single_element();
		send_element(32'h7FFF_FFFF);
		send_element(32'h8000_0000);
		send_element(32'hFFFF_FFFF);
		send_element(32'h0000_0000);
	endtask

	// zero taken as one
	task automatic test_zero_size();
		set_dims(4'd0, 4'd0);
		send_element(32'h5555_5555);
	endtask

	// 15 rows clamp to 8: one full column
	task automatic test_oversize();
		set_dims(4'd15, 4'd1);
		send_matrix(8);
	endtask

	// a register write part way through a load starts it again
	task automatic test_reload_restart();
		set_dims(4'd2, 4'd2);
		send_matrix(2);
		write_reg(smr_pkg::REG_COLUMN_COUNT, 4'd2);
		send_matrix(4);
	endtask

	task automatic test_single_row();
		set_dims(4'd1, 4'd3);
		send_matrix(3);
	endtask

	task automatic test_random_matrices(input int n_items);
		int target, total, cut;
		logic [smr_pkg::CFG_WIDTH-1:0] r_raw, c_raw;
		target = items_sent + n_items;
		while (items_sent < target) begin
			r_raw = pick_dim();
			c_raw = pick_dim();
			if ($urandom_range(15) == 0) begin
				r_raw = 4'd8;
				c_raw = 4'd8;
			end
			set_dims(r_raw, c_raw);
			total = clamp_dim(r_raw, MAX_ROWS) * clamp_dim(c_raw, MAX_COLS);
			repeat ($urandom_range(1, 4))
				if (items_sent < target)
					send_matrix(total);
			// abandoned load, cut short by the next size write
			if (items_sent < target && $urandom_range(99) < 12 && total > 1) begin
				cut = $urandom_range(1, total - 1);
				send_matrix(cut);
			end
		end
	endtask

	// long receiver hold-off fills the block; then the sender waits for the drain
	task automatic test_backpressure();
		set_dims(4'd4, 4'd4);
		recv_hold = 300;
		repeat (3)
			send_matrix(16);
		wait_idle();
		send_matrix(16);
	endtask

	initial begin
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = smr_pkg::REG_ROW_COUNT;
		cfg_wdata                = '0;
		element_ch.valid         = 1'b0;
		element_ch.element_value = '0;
		result_ch.ready          = 1'b0;
		shadow_rows              = 4'd1;
		shadow_cols              = 4'd1;
		shadow_fill              = 0;
		send_idle_pct            = 32;
		recv_idle_pct            = 87;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_element();
		test_zero_size();
		test_oversize();
		test_reload_restart();
		test_single_row();
		test_random_matrices(85);

		send_idle_pct = 87;
		recv_idle_pct = 32;
		test_random_matrices(85);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_matrices(85);

		wait_idle();
		repeat (16)
			@(posedge clk);

		$display("Loaded %0d elements into %0d complete matrices, from 1x1 up to 8x8,",
			items_sent, matrices_seen);
		$display("and checked %0d spiral beats under random stalls and a long hold-off.",
			beats_checked);
		if (mismatches == 0 && pending_spiral.size() == 0)
			$display("spiral_order_matrix_reader_tb OK");
		else
			$display("spiral_order_matrix_reader_tb NOT OK");
		$finish;
	end

	initial begin
		#20000000;
		$display("spiral_order_matrix_reader_tb NOT OK");
		$finish;
	end

endmodule
